// ===== rtl/core/yxy_pkg.sv =====
`timescale 1ns / 1ps

package yxy_pkg;

	localparam int IN_W     = 16;
	localparam int VAL_W    = 21;
	localparam int DIV_W    = IN_W + 1;
	localparam int QUOT_W   = VAL_W - 1;
	localparam int DVD_W    = 2 * IN_W + 2;
	localparam int DIV_STEPS = QUOT_W;
	localparam int COEF_W   = 19;
	localparam int PROD_W   = COEF_W + VAL_W;
	localparam int SUM_W    = PROD_W + 2;
	localparam int IN_DATA_W  = 3 * IN_W;
	localparam int OUT_DATA_W = 128;

	localparam logic signed [VAL_W-1:0] VAL_MAX = 21'sd1048575;
	localparam logic signed [VAL_W-1:0] VAL_MIN = -21'sd1048576;

	// XYZ to linear sRGB, Q2.16
	localparam logic signed [COEF_W-1:0] MAT_COEF [3][3] = '{
		'{ 19'sd212368, -19'sd100739, -19'sd32672},
		'{-19'sd63521,   19'sd122945,  19'sd2723},
		'{ 19'sd3647,   -19'sd13372,   19'sd69292}
	};

	typedef struct packed {
		logic              ovf;
		logic [DIV_W-1:0]  rem;
		logic [QUOT_W-1:0] dvd;
		logic [QUOT_W-1:0] quot;
	} div_lane_t;

	typedef struct packed {
		div_lane_t        x;
		div_lane_t        z;
		logic [DIV_W-1:0] div;
		logic [IN_W-1:0]  lum;
		logic             z_neg;
		logic             zero;
	} div_beat_t;

	typedef struct packed {
		logic                    zero;
		logic signed [VAL_W-1:0] tri_x;
		logic signed [VAL_W-1:0] tri_y;
		logic signed [VAL_W-1:0] tri_z;
		logic signed [VAL_W-1:0] red;
		logic signed [VAL_W-1:0] green;
		logic signed [VAL_W-1:0] blue;
	} out_beat_t;

endpackage

// ===== rtl/core/yxy_front.sv =====
`timescale 1ns / 1ps

module yxy_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [yxy_pkg::IN_W-1:0]          chroma_x,
	input  logic [yxy_pkg::IN_W-1:0]          chroma_y,
	input  logic [yxy_pkg::IN_W-1:0]          luminance,
	output logic                              out_valid,
	input  logic                              out_ready,
	output yxy_pkg::div_beat_t                out_beat
);
	import yxy_pkg::*;

	logic                 v_s1, v_s2;
	logic                 en_s1, en_s2;
	logic [2*IN_W-1:0]    prodx_s1;
	logic [2*IN_W:0]      prodz_s1;
	logic [IN_W-1:0]      cy_s1, lum_s1;
	logic                 neg_s1;
	logic [IN_W+1:0]      rest;
	logic [DIV_W-1:0]     mag;
	logic [DVD_W-1:0]     dx, dz;
	logic [DIV_W-1:0]     dv;
	logic [DIV_W-1:0]     hx, hz;
	logic                 ovfx, ovfz;
	div_beat_t            beat_s2;

	assign en_s2    = !v_s2 || out_ready;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	assign rest = 18'd65536 - {2'b0, chroma_x} - {2'b0, chroma_y};
	assign mag  = rest[IN_W+1] ? DIV_W'(~rest + 18'd1) : rest[DIV_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			prodx_s1 <= (2*IN_W)'(chroma_x) * (2*IN_W)'(luminance);
			prodz_s1 <= (2*IN_W+1)'(mag) * (2*IN_W+1)'(luminance);
			cy_s1    <= chroma_y;
			lum_s1   <= luminance;
			neg_s1   <= rest[IN_W+1];
		end
	end

	assign dx   = {1'b0, prodx_s1, 1'b0} + DVD_W'(cy_s1);
	assign dz   = {prodz_s1, 1'b0} + DVD_W'(cy_s1);
	assign dv   = {cy_s1, 1'b0};
	assign hx   = DIV_W'(dx[DVD_W-1:QUOT_W]);
	assign hz   = DIV_W'(dz[DVD_W-1:QUOT_W]);
	assign ovfx = hx >= dv;
	assign ovfz = hz >= dv;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			beat_s2.x.ovf  <= ovfx;
			beat_s2.x.rem  <= ovfx ? '0 : hx;
			beat_s2.x.dvd  <= dx[QUOT_W-1:0];
			beat_s2.x.quot <= '0;
			beat_s2.z.ovf  <= ovfz;
			beat_s2.z.rem  <= ovfz ? '0 : hz;
			beat_s2.z.dvd  <= dz[QUOT_W-1:0];
			beat_s2.z.quot <= '0;
			beat_s2.div    <= dv;
			beat_s2.lum    <= lum_s1;
			beat_s2.z_neg  <= neg_s1;
			beat_s2.zero   <= (cy_s1 == '0);
		end
	end

	assign out_valid = v_s2;
	assign out_beat  = beat_s2;

endmodule

// ===== rtl/core/yxy_div_cell.sv =====
`timescale 1ns / 1ps

module yxy_div_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  yxy_pkg::div_beat_t in_beat,
	output logic               out_valid,
	input  logic               out_ready,
	output yxy_pkg::div_beat_t out_beat
);
	import yxy_pkg::*;

	logic      v_q;
	logic      en;
	div_beat_t beat_q;
	div_beat_t nxt;

	function automatic div_lane_t step(input div_lane_t l, input logic [DIV_W-1:0] d);
		logic [DIV_W:0] sh;
		logic [DIV_W:0] diff;
		logic           ge;
		div_lane_t      r;
		sh     = {l.rem, l.dvd[QUOT_W-1]};
		diff   = sh - {1'b0, d};
		ge     = sh >= {1'b0, d};
		r.ovf  = l.ovf;
		r.rem  = ge ? diff[DIV_W-1:0] : sh[DIV_W-1:0];
		r.dvd  = {l.dvd[QUOT_W-2:0], 1'b0};
		r.quot = {l.quot[QUOT_W-2:0], ge};
		return r;
	endfunction

	assign en       = !v_q || out_ready;
	assign in_ready = en;

	always_comb begin
		nxt   = in_beat;
		nxt.x = step(in_beat.x, in_beat.div);
		nxt.z = step(in_beat.z, in_beat.div);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) beat_q <= nxt;
	end

	assign out_valid = v_q;
	assign out_beat  = beat_q;

endmodule

// ===== rtl/core/yxy_matrix.sv =====
`timescale 1ns / 1ps

module yxy_matrix (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  yxy_pkg::div_beat_t in_beat,
	output logic               out_valid,
	input  logic               out_ready,
	output yxy_pkg::out_beat_t out_beat
);
	import yxy_pkg::*;

	logic                     v_s1, v_s2, v_s3;
	logic                     en_s1, en_s2, en_s3;
	logic signed [VAL_W-1:0]  xv, zv;
	logic        [VAL_W-1:0]  zq;
	logic signed [VAL_W-1:0]  xyz_s1 [3];
	logic                     zero_s1, zero_s2;
	logic signed [VAL_W-1:0]  xyz_s2 [3];
	logic signed [PROD_W-1:0] prod_s2 [3][3];
	logic signed [SUM_W-1:0]  sum [3];
	logic signed [SUM_W-1:0]  rnd [3];
	logic signed [VAL_W-1:0]  sat [3];
	out_beat_t                beat_s3;

	assign en_s3    = !v_s3 || out_ready;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	assign zq = {1'b0, in_beat.z.quot};
	assign xv = in_beat.x.ovf ? VAL_MAX : $signed({1'b0, in_beat.x.quot});

	always_comb begin
		if (in_beat.z_neg) begin
			zv = in_beat.z.ovf ? VAL_MIN : $signed(~zq + 21'd1);
		end else begin
			zv = in_beat.z.ovf ? VAL_MAX : $signed(zq);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			zero_s1   <= in_beat.zero;
			xyz_s1[0] <= in_beat.zero ? '0 : xv;
			xyz_s1[1] <= in_beat.zero ? '0 : $signed(VAL_W'(in_beat.lum));
			xyz_s1[2] <= in_beat.zero ? '0 : zv;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			zero_s2 <= zero_s1;
			for (int i = 0; i < 3; i++) begin
				xyz_s2[i] <= xyz_s1[i];
				for (int j = 0; j < 3; j++) begin
					prod_s2[i][j] <= MAT_COEF[i][j] * xyz_s1[j];
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sum[i] = SUM_W'(prod_s2[i][0]) + SUM_W'(prod_s2[i][1]) + SUM_W'(prod_s2[i][2]);
			rnd[i] = (sum[i] + 42'sd32768) >>> 16;
			if (rnd[i] > SUM_W'(VAL_MAX)) begin
				sat[i] = VAL_MAX;
			end else if (rnd[i] < SUM_W'(VAL_MIN)) begin
				sat[i] = VAL_MIN;
			end else begin
				sat[i] = rnd[i][VAL_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			beat_s3.zero  <= zero_s2;
			beat_s3.tri_x <= xyz_s2[0];
			beat_s3.tri_y <= xyz_s2[1];
			beat_s3.tri_z <= xyz_s2[2];
			beat_s3.red   <= sat[0];
			beat_s3.green <= sat[1];
			beat_s3.blue  <= sat[2];
		end
	end

	assign out_valid = v_s3;
	assign out_beat  = beat_s3;

endmodule

// ===== rtl/core/yxy_to_linear_rgb.sv =====
// An accepted input beat passes the front, quotient cell and matrix stages in that order.
// Throughput: one beat per cycle when not stalled; 20 quotient cells, one bit per cell.
// Every stage holds its beat when the next one is full and stalled; bubbles collapse.
// Reset (arst_n low, asynchronous) clears all valid flags; data registers are not reset.
`timescale 1ns / 1ps

module yxy_to_linear_rgb (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// chroma_x, chroma_y, luminance
	input  logic [yxy_pkg::IN_DATA_W-1:0]       s_axis_tdata,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// tri_x, tri_y, tri_z, red, green, blue, two zero bits
	output logic [yxy_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
	// zero_chroma
	output logic [0:0]                          m_axis_tuser
);
	import yxy_pkg::*;

	logic      cv [DIV_STEPS+1];
	logic      cr [DIV_STEPS+1];
	div_beat_t cb [DIV_STEPS+1];
	out_beat_t ob;

	yxy_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.chroma_x  (s_axis_tdata[IN_W-1:0]),
		.chroma_y  (s_axis_tdata[2*IN_W-1:IN_W]),
		.luminance (s_axis_tdata[3*IN_W-1:2*IN_W]),
		.out_valid (cv[0]),
		.out_ready (cr[0]),
		.out_beat  (cb[0])
	);

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_cell
		yxy_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (cv[k]),
			.in_ready  (cr[k]),
			.in_beat   (cb[k]),
			.out_valid (cv[k+1]),
			.out_ready (cr[k+1]),
			.out_beat  (cb[k+1])
		);
	end

	yxy_matrix u_matrix (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cv[DIV_STEPS]),
		.in_ready  (cr[DIV_STEPS]),
		.in_beat   (cb[DIV_STEPS]),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_beat  (ob)
	);

	assign m_axis_tdata = {2'b00, ob.blue, ob.green, ob.red, ob.tri_z, ob.tri_y, ob.tri_x};
	assign m_axis_tuser = ob.zero;

	a_zero_clears : assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
		else $error("zero chroma beat carries non-zero data");

	a_x_nonneg : assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !ob.tri_x[VAL_W-1])
		else $error("tri_x negative");

	a_y_range : assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ob.tri_y[VAL_W-1:IN_W] == '0)
		else $error("tri_y beyond luminance range");

	a_ready_when_empty : assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid && !cv[DIV_STEPS] && !cv[0] |-> s_axis_tready)
		else $error("input stalled with an empty pipeline tail");

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

	import yxy_pkg::*;

	localparam longint SAT_HI = 1048575;
	localparam longint SAT_LO = -1048576;

	// XYZ to linear sRGB, Q2.16
	localparam longint SRGB_MAT [3][3] = '{
		'{ 212368, -100739, -32672},
		'{ -63521,  122945,   2723},
		'{   3647,  -13372,  69292}
	};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	// chroma_x, chroma_y, luminance
	logic [IN_DATA_W-1:0] s_axis_tdata = '0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	// tri_x, tri_y, tri_z, red, green, blue, two zero bits
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	// zero_chroma
	logic [0:0]           m_axis_tuser;

	out_beat_t expected_rgb [$];
	int        errors = 0;
	int        n_colours = 0;
	int        n_zero_y = 0;
	int        n_clipped = 0;
	int        n_neg_z = 0;
	int        burst_left = 0;
	bit        no_gaps = 1'b0;
	int        hold_cycles = 0;

	yxy_to_linear_rgb u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic longint clamp21(input longint v);
		if (v > SAT_HI)
			return SAT_HI;
		if (v < SAT_LO)
			return SAT_LO;
		return v;
	endfunction

	function automatic out_beat_t predict_rgb(input logic [15:0] cx, cy, lum);
		longint    num;
		longint    quot;
		longint    rest;
		longint    mag;
		longint    acc;
		longint    xyz [3];
		longint    rgb [3];
		out_beat_t r;
		r = '0;
		if (cy == 0) begin
			r.zero = 1'b1;
			return r;
		end
		num = longint'(cx) * longint'(lum);
		quot = (2 * num + longint'(cy)) / (2 * longint'(cy));
		xyz[0] = clamp21(quot);
		xyz[1] = longint'(lum);
		rest = 65536 - longint'(cx) - longint'(cy);
		mag = (rest < 0 ? -rest : rest) * longint'(lum);
		quot = (2 * mag + longint'(cy)) / (2 * longint'(cy));
		xyz[2] = clamp21(rest < 0 ? -quot : quot);
		for (int i = 0; i < 3; i++) begin
			acc = 0;
			for (int j = 0; j < 3; j++)
				acc += SRGB_MAT[i][j] * xyz[j];
			rgb[i] = clamp21((acc + 32768) >>> 16);
		end
		r.tri_x = xyz[0][VAL_W-1:0];
		r.tri_y = xyz[1][VAL_W-1:0];
		r.tri_z = xyz[2][VAL_W-1:0];
		r.red   = rgb[0][VAL_W-1:0];
		r.green = rgb[1][VAL_W-1:0];
		r.blue  = rgb[2][VAL_W-1:0];
		return r;
	endfunction

	// bursts of random length, random gaps between them
	task automatic send_colour(input logic [15:0] cx, cy, lum);
		int gap;
		if (!no_gaps && burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
				: $urandom_range(1, 24);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {lum, cy, cx};
		do
			@(posedge clk);
		while (!s_axis_tready);
		expected_rgb.push_back(predict_rgb(cx, cy, lum));
		n_colours++;
		if (burst_left > 0)
			burst_left--;
	endtask

	task automatic test_directed();
		send_colour(16'd0, 16'd0, 16'd0);
		send_colour(16'd65535, 16'd0, 16'd65535);
		send_colour(16'd12345, 16'd0, 16'd1);
		send_colour(16'd0, 16'd1, 16'd65535);
		send_colour(16'd65535, 16'd1, 16'd65535);
		send_colour(16'd65535, 16'd65535, 16'd65535);
		send_colour(16'd0, 16'd65535, 16'd0);
		send_colour(16'd0, 16'd65535, 16'd65535);
		send_colour(16'd65535, 16'd65535, 16'd1);
		send_colour(16'd32768, 16'd32768, 16'd4096);
		send_colour(16'd1, 16'd2, 16'd1);
		send_colour(16'd65535, 16'd2, 16'd1);
		send_colour(16'd3, 16'd2, 16'd1);
		send_colour(16'd20493, 16'd21561, 16'd4096);
		send_colour(16'd41943, 16'd21627, 16'd4096);
		send_colour(16'd19661, 16'd39322, 16'd4096);
		send_colour(16'd9830, 16'd3932, 16'd4096);
		send_colour(16'd21845, 16'd21845, 16'd65535);
		send_colour(16'd43690, 16'd43690, 16'd8192);
		send_colour(16'd1, 16'd65535, 16'd65535);
		send_colour(16'd65535, 16'd1, 16'd0);
		send_colour(16'hAAAA, 16'h5555, 16'hAAAA);
		send_colour(16'h5555, 16'hAAAA, 16'h5555);
	endtask

	task automatic random_colour();
		int          pick;
		logic [15:0] cx;
		logic [15:0] cy;
		logic [15:0] lum;
		pick = $urandom_range(0, 99);
		cx  = $urandom_range(0, 65535);
		cy  = $urandom_range(0, 65535);
		lum = $urandom_range(0, 65535);
		if (pick < 60) begin
			// plausible colours inside the gamut region
			cx = $urandom_range(0, 52000);
			cy = $urandom_range(1, 55000);
			if ($urandom_range(0, 1) == 1)
				lum = $urandom_range(0, 8192);
		end else if (pick < 85) begin
			cx = cx;
		end else if (pick < 92) begin
			cy = '0;
		end else begin
			cy = $urandom_range(1, 255);
		end
		send_colour(cx, cy, lum);
	endtask

	task automatic test_random(input int count);
		repeat (count) random_colour();
	endtask

	// hold the output off while the input keeps offering beats
	task automatic test_backpressure();
		no_gaps = 1'b1;
		hold_cycles = 300;
		repeat (100) random_colour();
		no_gaps = 1'b0;
	endtask

	// receiver stall pattern, changes mode every so often
	initial begin
		int mode;
		int span;
		mode = 0;
		span = 0;
		forever begin
			@(posedge clk);
			if (span == 0) begin
				mode = $urandom_range(0, 3);
				span = $urandom_range(32, 256);
			end
			span--;
			if (hold_cycles > 0) begin
				m_axis_tready <= 1'b0;
				hold_cycles--;
			end else begin
				case (mode)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= ($urandom_range(0, 1) == 1);
					2: m_axis_tready <= ($urandom_range(0, 7) != 0);
					default: m_axis_tready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	task automatic check_field(input string name, input logic [VAL_W-1:0] exp_v, act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0d, got %0d", name, $signed(exp_v), $signed(act_v));
			errors++;
		end
	endtask

	initial begin
		out_beat_t exp_b;
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready) begin
				if (expected_rgb.size() == 0) begin
					$error("unexpected output beat: tdata %h", m_axis_tdata);
					errors++;
				end else begin
					exp_b = expected_rgb.pop_front();
					check_field("tri_x", exp_b.tri_x, m_axis_tdata[0*VAL_W +: VAL_W]);
					check_field("tri_y", exp_b.tri_y, m_axis_tdata[1*VAL_W +: VAL_W]);
					check_field("tri_z", exp_b.tri_z, m_axis_tdata[2*VAL_W +: VAL_W]);
					check_field("red", exp_b.red, m_axis_tdata[3*VAL_W +: VAL_W]);
					check_field("green", exp_b.green, m_axis_tdata[4*VAL_W +: VAL_W]);
					check_field("blue", exp_b.blue, m_axis_tdata[5*VAL_W +: VAL_W]);
					check_field("pad", '0, VAL_W'(m_axis_tdata[OUT_DATA_W-1:6*VAL_W]));
					check_field("zero_chroma", VAL_W'(exp_b.zero), VAL_W'(m_axis_tuser[0]));
					if (exp_b.zero)
						n_zero_y++;
					if (exp_b.tri_z < 0)
						n_neg_z++;
					if (exp_b.tri_x == VAL_MAX || exp_b.tri_z == VAL_MIN
						|| exp_b.tri_z == VAL_MAX || exp_b.red == VAL_MAX
						|| exp_b.red == VAL_MIN || exp_b.green == VAL_MAX
						|| exp_b.green == VAL_MIN || exp_b.blue == VAL_MAX
						|| exp_b.blue == VAL_MIN)
						n_clipped++;
				end
			end
		end
	end

	initial begin
		#2_000_000;
		$display("tb_top: errors");
		$finish;
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(700);
		test_backpressure();
		test_random(727);
		s_axis_tvalid <= 1'b0;
		while (expected_rgb.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		$display("colours sent %0d: y zero %0d, negative Z %0d, clipped %0d",
			n_colours, n_zero_y, n_neg_z, n_clipped);
		$display("covered field extremes, rounding ties, gaps, stalls and a long hold-off");
		if (errors == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/yxy_pkg.sv
rtl/core/yxy_front.sv
rtl/core/yxy_div_cell.sv
rtl/core/yxy_matrix.sv
rtl/core/yxy_to_linear_rgb.sv
dv/tb_top.sv
